/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a |-> c, sampled on clk, off while rst_n is low
`define AM_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// a |=> c, sampled on clk, off while rst_n is low
`define AM_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* rtl/mcpq_pkg.sv */
// Shared types and constants for the moving cylinder point query core.
// No dependencies.
package mcpq_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    typedef enum logic [2:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_START_TIME,
        CFG_END_X,
        CFG_END_Y,
        CFG_END_TIME,
        CFG_MAX_RADIUS,
        CFG_RADIUS_SLOPE
    } t_cfg_idx;

    // where the query time falls against the span
    typedef enum logic [1:0] {
        CLS_BEFORE,
        CLS_AFTER,
        CLS_INSIDE
    } t_cls;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_time;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [31:0] end_time;
        logic [30:0] max_radius;
        logic [31:0] radius_slope;
    } t_cfg;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        t_cls        cls;
        logic [31:0] rise;
        logic [31:0] fall;
        logic [31:0] span;
    } t_front_item;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        t_cls        cls;
        logic [30:0] r;
    } t_div_sb;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        t_cls        cls;
        logic [30:0] r;
    } t_sqrt_sb;

endpackage

/* rtl/mcpq_front.sv */
// Front end: classifies a query time against the span and forms the time deltas.
// Depends on mcpq_pkg.
module mcpq_front (
    input  mcpq_pkg::t_cfg        i_cfg,
    input  logic [31:0]           i_qx,
    input  logic [31:0]           i_qy,
    input  logic [31:0]           i_t,
    output mcpq_pkg::t_front_item o_item
);

    always_comb begin
        o_item.qx   = i_qx;
        o_item.qy   = i_qy;
        o_item.rise = 32'd0;
        o_item.fall = 32'd0;
        o_item.span = 32'd1;
        priority if (i_t <= i_cfg.start_time) begin
            o_item.cls = mcpq_pkg::CLS_BEFORE;
        end else if (i_t >= i_cfg.end_time) begin
            o_item.cls = mcpq_pkg::CLS_AFTER;
        end else begin
            o_item.cls  = mcpq_pkg::CLS_INSIDE;
            o_item.rise = i_t - i_cfg.start_time;
            o_item.fall = i_cfg.end_time - i_t;
            o_item.span = i_cfg.end_time - i_cfg.start_time;
        end
    end

endmodule

/* rtl/mcpq_queue.sv */
// Short request queue between the front end and the arithmetic back end.
// Depends on mcpq_pkg.
module mcpq_queue #(
    parameter int DEPTH = mcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mcpq_pkg::t_front_item i_data,
    input  logic                  i_pop,
    output mcpq_pkg::t_front_item o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mcpq_pkg::t_front_item r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/mcpq_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Quotient must fit 33 bits (numerator below divisor * 2^33). No dependencies.
module mcpq_div #(
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [64:0]    i_num_x,
    input  logic [64:0]    i_num_y,
    input  logic [31:0]    i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [32:0]    o_quo_x,
    output logic [32:0]    o_quo_y,
    output logic [SBW-1:0] o_sb
);

    localparam int QW = 33;

    logic [QW:0]    r_v;
    logic [31:0]    r_remx [0:QW];
    logic [31:0]    r_remy [0:QW];
    logic [32:0]    r_lowx [0:QW];
    logic [32:0]    r_lowy [0:QW];
    logic [32:0]    r_qx   [0:QW];
    logic [32:0]    r_qy   [0:QW];
    logic [31:0]    r_den  [0:QW];
    logic [SBW-1:0] r_sb   [0:QW];

    logic [31:0] n_remx [1:QW];
    logic [31:0] n_remy [1:QW];
    logic [32:0] catx   [0:QW-1];
    logic [32:0] caty   [0:QW-1];
    logic [32:0] subx   [0:QW-1];
    logic [32:0] suby   [0:QW-1];
    logic        gex    [0:QW-1];
    logic        gey    [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            catx[k] = {r_remx[k], r_lowx[k][32]};
            caty[k] = {r_remy[k], r_lowy[k][32]};
            subx[k] = catx[k] - {1'b0, r_den[k]};
            suby[k] = caty[k] - {1'b0, r_den[k]};
            gex[k]  = (catx[k] >= {1'b0, r_den[k]});
            gey[k]  = (caty[k] >= {1'b0, r_den[k]});
            n_remx[k+1] = gex[k] ? subx[k][31:0] : catx[k][31:0];
            n_remy[k+1] = gey[k] ? suby[k][31:0] : caty[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_remx[0] <= i_num_x[64:33];
            r_remy[0] <= i_num_y[64:33];
            r_lowx[0] <= i_num_x[32:0];
            r_lowy[0] <= i_num_y[32:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_den[0]  <= i_den;
            r_sb[0]   <= i_sb;
            for (int k = 0; k < QW; k++) begin
                r_remx[k+1] <= n_remx[k+1];
                r_remy[k+1] <= n_remy[k+1];
                r_lowx[k+1] <= {r_lowx[k][31:0], 1'b0};
                r_lowy[k+1] <= {r_lowy[k][31:0], 1'b0};
                r_qx[k+1]   <= {r_qx[k][31:0], gex[k]};
                r_qy[k+1]   <= {r_qy[k][31:0], gey[k]};
                r_den[k+1]  <= r_den[k];
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo_x = r_qx[QW];
    assign o_quo_y = r_qy[QW];
    assign o_sb    = r_sb[QW];

endmodule

/* rtl/mcpq_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
// 66-bit radicand, 33-bit floor root. No dependencies.
module mcpq_sqrt #(
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [65:0]    i_rad,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [32:0]    o_root,
    output logic [SBW-1:0] o_sb
);

    localparam int QW = 33;

    logic [QW:0]    r_v;
    logic [35:0]    r_rem  [0:QW];
    logic [65:0]    r_rad  [0:QW];
    logic [32:0]    r_root [0:QW];
    logic [SBW-1:0] r_sb   [0:QW];

    logic [35:0] cat   [0:QW-1];
    logic [35:0] trial [0:QW-1];
    logic        ge    [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            cat[k]   = {r_rem[k][33:0], r_rad[k][65:64]};
            trial[k] = {1'b0, r_root[k], 2'b01};
            ge[k]    = (cat[k] >= trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_rad[0]  <= i_rad;
            r_root[0] <= '0;
            r_sb[0]   <= i_sb;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= ge[k] ? (cat[k] - trial[k]) : cat[k];
                r_rad[k+1]  <= {r_rad[k][63:0], 2'b00};
                r_root[k+1] <= {r_root[k][31:0], ge[k]};
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_root  = r_root[QW];
    assign o_sb    = r_sb[QW];

endmodule

/* rtl/mcpq_back.sv */
// Back end: products, centre interpolation, radius, distance and output register.
// Depends on mcpq_pkg, mcpq_div, mcpq_sqrt.
module mcpq_back #(
    parameter int FRACTION_BITS = mcpq_pkg::FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcpq_pkg::t_cfg        i_cfg,
    input  mcpq_pkg::t_front_item i_q_item,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [32:0]           o_outside_distance,
    output logic signed [31:0]    o_centre_x,
    output logic signed [31:0]    o_centre_y,
    output logic [30:0]           o_radius_now
);

    localparam int DSBW = $bits(mcpq_pkg::t_div_sb);
    localparam int SSBW = $bits(mcpq_pkg::t_sqrt_sb);

    logic adv;

    // per-axis centre travel; user keeps config fixed in flight, unchecked here
    logic [32:0] dxs, dys, magx, magy;

    // multiply stage
    logic                  r_m_v;
    mcpq_pkg::t_front_item r_m;
    logic [64:0]           r_px, r_py;
    logic [63:0]           r_pr1, r_pr2;

    logic [63:0]      sh1, sh2;
    logic [30:0]      rad;
    mcpq_pkg::t_div_sb dsb_in, dsb_out;
    logic [DSBW-1:0]  dsb_out_bits;
    logic             d_valid;
    logic [32:0]      quo_x, quo_y;

    // centre stage
    logic             r_f_v;
    mcpq_pkg::t_div_sb r_f;
    logic [31:0]      r_cx, r_cy;
    logic [33:0]      lerp_x, lerp_y;
    logic [31:0]      n_cx, n_cy;

    // square stage
    logic             r_s_v;
    mcpq_pkg::t_sqrt_sb r_s;
    logic [65:0]      r_sx, r_sy;
    logic [32:0]      ddx, ddy, adx, ady;

    mcpq_pkg::t_sqrt_sb ssb_in, ssb_out;
    logic [SSBW-1:0]  ssb_out_bits;
    logic             s_valid;
    logic [32:0]      sq_root;

    logic r_out_valid;

    assign adv     = !r_out_valid || !i_out_stall;
    assign o_q_pop = adv && !i_q_empty;

    assign dxs  = {i_cfg.end_x[31], i_cfg.end_x} - {i_cfg.start_x[31], i_cfg.start_x};
    assign dys  = {i_cfg.end_y[31], i_cfg.end_y} - {i_cfg.start_y[31], i_cfg.start_y};
    assign magx = dxs[32] ? (33'd0 - dxs) : dxs;
    assign magy = dys[32] ? (33'd0 - dys) : dys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m   <= i_q_item;
            r_px  <= magx * i_q_item.rise;
            r_py  <= magy * i_q_item.rise;
            r_pr1 <= i_q_item.rise * i_cfg.radius_slope;
            r_pr2 <= i_q_item.fall * i_cfg.radius_slope;
        end
    end

    // radius in span: min of ceiling and ramps, ceiling for all-ones slope; else zero
    always_comb begin
        sh1 = r_pr1 >> FRACTION_BITS;
        sh2 = r_pr2 >> FRACTION_BITS;
        rad = i_cfg.max_radius;
        if (i_cfg.radius_slope != '1) begin
            if (sh1 < {33'd0, rad}) begin
                rad = sh1[30:0];
            end
            if (sh2 < {33'd0, rad}) begin
                rad = sh2[30:0];
            end
        end
        if (r_m.cls != mcpq_pkg::CLS_INSIDE) begin
            rad = '0;
        end
        dsb_in.qx  = r_m.qx;
        dsb_in.qy  = r_m.qy;
        dsb_in.cls = r_m.cls;
        dsb_in.r   = rad;
    end

    mcpq_div #(
        .SBW (DSBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_m_v),
        .i_num_x (r_px),
        .i_num_y (r_py),
        .i_den   (r_m.span),
        .i_sb    (dsb_in),
        .o_valid (d_valid),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y),
        .o_sb    (dsb_out_bits)
    );

    assign dsb_out = mcpq_pkg::t_div_sb'(dsb_out_bits);

    always_comb begin
        lerp_x = dxs[32] ? ({{2{i_cfg.start_x[31]}}, i_cfg.start_x} - {1'b0, quo_x})
                         : ({{2{i_cfg.start_x[31]}}, i_cfg.start_x} + {1'b0, quo_x});
        lerp_y = dys[32] ? ({{2{i_cfg.start_y[31]}}, i_cfg.start_y} - {1'b0, quo_y})
                         : ({{2{i_cfg.start_y[31]}}, i_cfg.start_y} + {1'b0, quo_y});
        unique case (dsb_out.cls)
            mcpq_pkg::CLS_BEFORE: begin
                n_cx = i_cfg.start_x;
                n_cy = i_cfg.start_y;
            end
            mcpq_pkg::CLS_AFTER: begin
                n_cx = i_cfg.end_x;
                n_cy = i_cfg.end_y;
            end
            mcpq_pkg::CLS_INSIDE: begin
                n_cx = lerp_x[31:0];
                n_cy = lerp_y[31:0];
            end
            default: begin
                n_cx = i_cfg.start_x;
                n_cy = i_cfg.start_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (adv) begin
            r_f_v <= d_valid;
            r_s_v <= r_f_v;
        end
    end

    assign ddx = {r_f.qx[31], r_f.qx} - {r_cx[31], r_cx};
    assign ddy = {r_f.qy[31], r_f.qy} - {r_cy[31], r_cy};
    assign adx = ddx[32] ? (33'd0 - ddx) : ddx;
    assign ady = ddy[32] ? (33'd0 - ddy) : ddy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f      <= dsb_out;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_s.cx   <= r_cx;
            r_s.cy   <= r_cy;
            r_s.cls  <= r_f.cls;
            r_s.r    <= r_f.r;
            r_sx     <= adx * adx;
            r_sy     <= ady * ady;
        end
    end

    assign ssb_in = r_s;

    mcpq_sqrt #(
        .SBW (SSBW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s_v),
        .i_rad   (r_sx + r_sy),
        .i_sb    (ssb_in),
        .o_valid (s_valid),
        .o_root  (sq_root),
        .o_sb    (ssb_out_bits)
    );

    assign ssb_out = mcpq_pkg::t_sqrt_sb'(ssb_out_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_hit              <= (ssb_out.cls == mcpq_pkg::CLS_INSIDE) &&
                                  (sq_root < {2'b00, ssb_out.r});
            o_outside_distance <= (sq_root < {2'b00, ssb_out.r}) ? 33'd0
                                                                 : sq_root - {2'b00, ssb_out.r};
            o_centre_x         <= ssb_out.cx;
            o_centre_y         <= ssb_out.cy;
            o_radius_now       <= ssb_out.r;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/moving_cylinder_point_query_core.sv */
// Moving cylinder point query core: tests (x, y, t) against a moving cylinder.
// A result passes the queue, multiply, divider, centre, square, root and output registers.
// Throughput: one request per cycle unless stalled, set by the divider and root pipelines.
// Reset (synchronous, active low) empties the queue and pipeline; config returns to
// zero with an unlimited slope.
// Depends on mcpq_pkg, mcpq_front, mcpq_queue, mcpq_back.
module moving_cylinder_point_query_core #(
    parameter int FRACTION_BITS = mcpq_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = mcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    input  logic [31:0]        i_query_time,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [32:0]        o_outside_distance,
    output logic signed [31:0] o_centre_x,
    output logic signed [31:0] o_centre_y,
    output logic [30:0]        o_radius_now
);

    mcpq_pkg::t_cfg        r_cfg;
    mcpq_pkg::t_front_item front_item, q_item;
    logic                  q_full, q_empty, q_pop;

    // config is always writable; software must write only while idle, unchecked by the block
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{radius_slope: '1, default: '0};
        end else if (i_cfg_valid) begin
            unique case (mcpq_pkg::t_cfg_idx'(i_cfg_index))
                mcpq_pkg::CFG_START_X:      r_cfg.start_x      <= i_cfg_data;
                mcpq_pkg::CFG_START_Y:      r_cfg.start_y      <= i_cfg_data;
                mcpq_pkg::CFG_START_TIME:   r_cfg.start_time   <= i_cfg_data;
                mcpq_pkg::CFG_END_X:        r_cfg.end_x        <= i_cfg_data;
                mcpq_pkg::CFG_END_Y:        r_cfg.end_y        <= i_cfg_data;
                mcpq_pkg::CFG_END_TIME:     r_cfg.end_time     <= i_cfg_data;
                mcpq_pkg::CFG_MAX_RADIUS:   r_cfg.max_radius   <= i_cfg_data[30:0];
                mcpq_pkg::CFG_RADIUS_SLOPE: r_cfg.radius_slope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: classify the request time and form rise/fall/span
    mcpq_front u_front (
        .i_cfg  (r_cfg),
        .i_qx   (i_query_x),
        .i_qy   (i_query_y),
        .i_t    (i_query_time),
        .o_item (front_item)
    );

    // stall only on a full queue, so the front keeps taking requests
    // while the back end holds a result
    assign o_in_stall = q_full;

    mcpq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: multiplies, divider lanes, centre, squares, root, output register
    mcpq_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_item           (q_item),
        .i_q_empty          (q_empty),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_outside_distance (o_outside_distance),
        .o_centre_x         (o_centre_x),
        .o_centre_y         (o_centre_y),
        .o_radius_now       (o_radius_now)
    );

endmodule

/* rtl/mcpq_checker.sv */
// Port-level checks for the moving cylinder point query core, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mcpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_hit,
    input logic [32:0] o_outside_distance,
    input logic [31:0] o_centre_x,
    input logic [30:0] o_radius_now
);

    `AM_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_centre_x) && $stable(o_outside_distance))
    `AM_IMPL(a_hit_no_dist, i_clk, i_rst_n, o_out_valid && o_hit, o_outside_distance == 33'd0)
    `AM_IMPL(a_hit_radius, i_clk, i_rst_n, o_out_valid && o_hit, o_radius_now != 31'd0)
    `AM_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind moving_cylinder_point_query_core mcpq_checker u_chk (.*);

/* test/tb_moving_cylinder_point_query_core.sv */
`timescale 1ns / 1ps
// Testbench for moving_cylinder_point_query_core: directed tables, then random phases.
// Results are checked against typed rows or an in-bench cylinder predictor.
// Depends on mcpq_pkg and moving_cylinder_point_query_core.
module tb_moving_cylinder_point_query_core;

    localparam int FRAC       = mcpq_pkg::FRACTION_BITS_DEF;
    localparam int DRAIN_WAIT = 90;     // extra wait once no result is owed, so the pipeline flushes
    localparam int IDLE_LIMIT = 3000;   // longest output stall plus longest request gap plus the pipeline, with margin
    localparam int N_PHASES   = 12;
    localparam int PER_PHASE  = 50;

    typedef struct {
        bit          hit;
        logic [32:0] dist_out;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] r;
    } t_cyl_result;

    typedef struct {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qt;
        t_cyl_result res;
    } t_query_req;

    // directed row; typed rows carry their expected result
    typedef struct {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qt;
        bit          typed;
        t_cyl_result res;
    } t_query_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic signed [31:0] i_query_x = '0;
    logic signed [31:0] i_query_y = '0;
    logic [31:0] i_query_time = '0;
    logic        i_out_stall = 1'b0;
    logic        o_cfg_ready, o_in_stall, o_out_valid, o_hit;
    logic [32:0] o_outside_distance;
    logic signed [31:0] o_centre_x, o_centre_y;
    logic [30:0] o_radius_now;

    moving_cylinder_point_query_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    mcpq_pkg::t_cfg cyl_cfg;           // predictor copy of the registers
    t_query_req  pending_queries[$];   // requests waiting to be offered
    t_cyl_result expected_results[$];  // results owed by the block
    int          err_count = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;          // phase without gaps or stalls
    bit          hold_req = 0;         // ask the receiver for one long hold-off

    function automatic logic signed [63:0] sext32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // centre between a and b at num/den; magnitude product wraps at 64 bits
    function automatic logic signed [63:0] lerp_centre(logic signed [63:0] a,
            logic signed [63:0] b, logic [63:0] num, logic [63:0] den);
        logic signed [63:0] d;
        logic [63:0] mag, prod, m;
        d    = b - a;
        mag  = d < 0 ? -d : d;
        prod = mag * num;
        m    = prod / den;
        return d < 0 ? a - $signed(m) : a + $signed(m);
    endfunction

    function automatic t_cyl_result predict_cylinder(mcpq_pkg::t_cfg c, logic [31:0] qx,
            logic [31:0] qy, logic [31:0] qt);
        t_cyl_result o;
        logic signed [63:0] cx, cy, dx, dy;
        logic [63:0] span, rise, fall, r, r1, r2, ax, ay;
        logic [127:0] sum, cand;
        logic [63:0] root;
        bit in_span;
        r = 0;
        in_span = (qt >= c.start_time) && (qt <= c.end_time);
        if (qt <= c.start_time) begin
            cx = sext32(c.start_x);
            cy = sext32(c.start_y);
        end else if (qt >= c.end_time) begin
            cx = sext32(c.end_x);
            cy = sext32(c.end_y);
        end else begin
            span = 64'(c.end_time) - 64'(c.start_time);
            rise = 64'(qt) - 64'(c.start_time);
            fall = 64'(c.end_time) - 64'(qt);
            cx = lerp_centre(sext32(c.start_x), sext32(c.end_x), rise, span);
            cy = lerp_centre(sext32(c.start_y), sext32(c.end_y), rise, span);
            r = 64'(c.max_radius);
            if (c.radius_slope != '1) begin
                r1 = (rise * 64'(c.radius_slope)) >> FRAC;
                r2 = (fall * 64'(c.radius_slope)) >> FRAC;
                if (r1 < r) r = r1;
                if (r2 < r) r = r2;
            end
        end
        dx = sext32(qx) - cx;
        dy = sext32(qy) - cy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sum = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        root = 0;
        for (int b = 32; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sum) root = cand[63:0];
        end
        o.hit      = in_span && (root < r);
        o.dist_out = (root < r) ? 33'd0 : 33'(root - r);
        o.cx       = cx[31:0];
        o.cy       = cy[31:0];
        o.r        = r[30:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_scaled();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // one phase's register values, by index; some phases are fixed extremes
    function automatic void make_phase_cfg(int ph, output logic [31:0] v[8]);
        logic [31:0] st, sp;
        case (ph % 6)
            0: v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
            1: v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0};
            default: begin
                st = $urandom;
                sp = rand_scaled();
                if ($urandom_range(0, 3) == 0) sp = $urandom_range(1, 3);
                v[mcpq_pkg::CFG_START_X] = $urandom_range(0, 1) ? $urandom : rand_scaled();
                v[mcpq_pkg::CFG_START_Y] = $urandom_range(0, 1) ? $urandom : -rand_scaled();
                v[mcpq_pkg::CFG_END_X]   = $urandom_range(0, 1) ? $urandom : -rand_scaled();
                v[mcpq_pkg::CFG_END_Y]   = $urandom_range(0, 1) ? $urandom : rand_scaled();
                v[mcpq_pkg::CFG_START_TIME] = st;
                v[mcpq_pkg::CFG_END_TIME]   = (64'(st) + sp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                             : st + sp;
                v[mcpq_pkg::CFG_MAX_RADIUS]   = {1'($urandom), 31'(rand_scaled())};
                v[mcpq_pkg::CFG_RADIUS_SLOPE] = rand_scaled();
                if (ph % 6 == 2) begin
                    // end before start: radius stays zero
                    v[mcpq_pkg::CFG_START_TIME] = v[mcpq_pkg::CFG_END_TIME] | 32'h1;
                    v[mcpq_pkg::CFG_END_TIME]   = v[mcpq_pkg::CFG_START_TIME] >> 1;
                end
                if (ph % 6 == 3) v[mcpq_pkg::CFG_RADIUS_SLOPE] = '1;
            end
        endcase
    endfunction

    // random query, mostly inside the span and near the centre
    function automatic t_query_req make_query(mcpq_pkg::t_cfg c);
        t_query_req q;
        t_cyl_result ctr;
        logic [63:0] span, mag;
        logic signed [63:0] off;
        int p;
        p = $urandom_range(0, 99);
        if (p < 75 && c.end_time >= c.start_time) begin
            span = 64'(c.end_time) - 64'(c.start_time) + 1;
            q.qt = 32'(64'(c.start_time) + ({$urandom, $urandom} % span));
        end else begin
            case ($urandom_range(0, 4))
                0: q.qt = c.start_time;
                1: q.qt = c.end_time;
                2: q.qt = '0;
                3: q.qt = '1;
                default: q.qt = $urandom;
            endcase
        end
        if ($urandom_range(0, 99) < 15) begin
            q.qx = $urandom;
            q.qy = $urandom;
        end else begin
            ctr = predict_cylinder(c, '0, '0, q.qt);
            mag = 64'(ctr.r) * 2 + ($urandom & 32'hFF);
            off = $signed({$urandom, $urandom} % (mag + 1));
            q.qx = ctr.cx + 32'($urandom_range(0, 1) ? off : -off);
            off = $signed({$urandom, $urandom} % (mag + 1));
            q.qy = ctr.cy + 32'($urandom_range(0, 1) ? off : -off);
        end
        q.res = predict_cylinder(c, q.qx, q.qy, q.qt);
        return q;
    endfunction

    task automatic write_reg(mcpq_pkg::t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            mcpq_pkg::CFG_START_X:      cyl_cfg.start_x      = data;
            mcpq_pkg::CFG_START_Y:      cyl_cfg.start_y      = data;
            mcpq_pkg::CFG_START_TIME:   cyl_cfg.start_time   = data;
            mcpq_pkg::CFG_END_X:        cyl_cfg.end_x        = data;
            mcpq_pkg::CFG_END_Y:        cyl_cfg.end_y        = data;
            mcpq_pkg::CFG_END_TIME:     cyl_cfg.end_time     = data;
            mcpq_pkg::CFG_MAX_RADIUS:   cyl_cfg.max_radius   = data[30:0];
            mcpq_pkg::CFG_RADIUS_SLOPE: cyl_cfg.radius_slope = data;
            default: ;
        endcase
    endtask

    // block idle: nothing queued, nothing on the wire, nothing owed, pipe flushed
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_queries.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_cfg(logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(mcpq_pkg::t_cfg_idx'(i), v[i]);
    endtask

    // --- request side: one NBA per signal per edge ---
    initial begin
        t_query_req cur;
        int gap_left;
        gap_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (i_in_valid && !o_in_stall) expected_results.push_back(cur.res);
            if (i_in_valid && o_in_stall) begin
                // stalled: payload holds
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_queries.size() != 0) begin
                cur = pending_queries.pop_front();
                i_query_x    <= cur.qx;
                i_query_y    <= cur.qy;
                i_query_time <= cur.qt;
                i_in_valid   <= 1'b1;
                gap_left = no_idle ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // --- result side: stall runs, field-by-field compare ---
    initial begin
        t_cyl_result e;
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_hit !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, o_hit);
                        err_count++;
                    end
                    if (o_outside_distance !== e.dist_out) begin
                        $error("outside_distance: expected %h, got %h", e.dist_out,
                               o_outside_distance);
                        err_count++;
                    end
                    if (o_centre_x !== e.cx) begin
                        $error("centre_x: expected %h, got %h", e.cx, o_centre_x);
                        err_count++;
                    end
                    if (o_centre_y !== e.cy) begin
                        $error("centre_y: expected %h, got %h", e.cy, o_centre_y);
                        err_count++;
                    end
                    if (o_radius_now !== e.r) begin
                        $error("radius_now: expected %h, got %h", e.r, o_radius_now);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_req) begin
                hold_req = 0;
                stall_left = 400;
                i_out_stall <= 1'b1;
            end else if (no_idle || $urandom_range(0, 1)) begin
                stall_left = $urandom_range(0, 7);
                i_out_stall <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_out_stall <= 1'b1;
            end
        end
    end

    // cycles in which no channel moves
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb_moving_cylinder_point_query_core: done, errors");
        $finish;
    end

    // --- main sequence ---
    initial begin
        t_query_row  reset_rows[$];
        t_query_row  span_rows[$];
        t_query_req  q;
        logic [31:0] v[8];
        cyl_cfg = '{default: '0};
        cyl_cfg.radius_slope = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: zero span, so centre is the origin and the radius is zero
        reset_rows = '{
            '{32'h0, 32'h0, 32'h0, 1, '{0, 33'h0, 32'h0, 32'h0, 31'h0}},
            '{32'h8000_0000, 32'h0, 32'h0, 1, '{0, 33'h8000_0000, 32'h0, 32'h0, 31'h0}},
            '{32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1,
              '{0, 33'h7FFF_FFFF, 32'h0, 32'h0, 31'h0}},
            '{32'h0, 32'h8000_0000, 32'h1234_5678, 1,
              '{0, 33'h8000_0000, 32'h0, 32'h0, 31'h0}},
            '{32'h8000_0000, 32'h8000_0000, 32'h0, 1,
              '{0, 33'd3037000499, 32'h0, 32'h0, 31'h0}},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
              '{0, 33'd3037000498, 32'h0, 32'h0, 31'h0}},
            '{32'h0003_0000, 32'hFFFC_0000, 32'h5, 1, '{0, 33'h5_0000, 32'h0, 32'h0, 31'h0}}
        };
        foreach (reset_rows[i]) begin
            q.qx = reset_rows[i].qx;
            q.qy = reset_rows[i].qy;
            q.qt = reset_rows[i].qt;
            q.res = reset_rows[i].typed ? reset_rows[i].res
                                        : predict_cylinder(cyl_cfg, q.qx, q.qy, q.qt);
            pending_queries.push_back(q);
        end
        wait_drained();

        // small span, unit slope: ramp up, plateau, ramp down, both edges of the span
        v = '{32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000,
              32'h0005_0000, 32'h0000_8000, 32'h0001_0000};
        program_cfg(v);
        span_rows = '{
            '{32'hFFFF_0000, 32'h0, 32'h0001_0000, 0, '{default: '0}},
            '{32'hFFFF_0000, 32'h0, 32'h0001_0001, 0, '{default: '0}},
            '{32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 0, '{default: '0}},
            '{32'h0001_4000, 32'h0001_0000, 32'h0003_0000, 0, '{default: '0}},
            '{32'h0001_7FFF, 32'h0001_0000, 32'h0003_0000, 0, '{default: '0}},
            '{32'h0003_0000, 32'h0002_0000, 32'h0004_FFFF, 0, '{default: '0}},
            '{32'h0003_0000, 32'h0002_0000, 32'h0005_0000, 0, '{default: '0}},
            '{32'h0003_0000, 32'h0002_0000, 32'hFFFF_FFFF, 0, '{default: '0}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, 0, '{default: '0}},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, '{default: '0}},
            '{32'h0001_2000, 32'h0000_E000, 32'h0003_0000, 0, '{default: '0}}
        };
        foreach (span_rows[i]) begin
            q = '{span_rows[i].qx, span_rows[i].qy, span_rows[i].qt,
                  predict_cylinder(cyl_cfg, span_rows[i].qx, span_rows[i].qy,
                                   span_rows[i].qt)};
            pending_queries.push_back(q);
        end
        wait_drained();

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            make_phase_cfg(ph, v);
            program_cfg(v);
            no_idle = (ph == 2 || ph == 7);
            if (ph == 4) hold_req = 1;   // receiver holds while requests keep coming
            for (int k = 0; k < PER_PHASE; k++) pending_queries.push_back(make_query(cyl_cfg));
            wait_drained();
        end

        if (err_count == 0)
            $display("tb_moving_cylinder_point_query_core: done, clean");
        else
            $display("tb_moving_cylinder_point_query_core: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/mcpq_pkg.sv
rtl/mcpq_front.sv
rtl/mcpq_queue.sv
rtl/mcpq_div.sv
rtl/mcpq_sqrt.sv
rtl/mcpq_back.sv
rtl/moving_cylinder_point_query_core.sv
rtl/mcpq_checker.sv
test/tb_moving_cylinder_point_query_core.sv
